### hdl/b64e_pkg.sv
// Shared types, constants and the Base64 alphabet lookup for the stream encoder.
// No dependencies; every other file of the encoder imports this package.
`default_nettype none

package b64e_pkg;

    // Pad character '=' in ASCII.
    localparam logic [6:0] PAD_CHAR = 7'h3D;

    // Position of the next byte within its three-byte group.
    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;

    // One classified byte: the characters it produces, in output order.
    typedef struct packed {
        logic [3:0][6:0] chars;     // chars[0] goes out first
        logic [1:0]      last_idx;  // index of the final character of this job
        logic            is_final;  // job closes the message
    } job_t;

    // Status of the job queue as seen by the front and back parts.
    typedef struct packed {
        logic full;
        logic nonempty;
    } q_stat_t;

    // Maps a six-bit sextet onto its character of the standard alphabet.
    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] c;
        if (v < 6'd26)
        begin
            c = 7'h41 + {1'b0, v};
        end
        else if (v < 6'd52)
        begin
            c = 7'h61 + ({1'b0, v} - 7'd26);
        end
        else if (v < 6'd62)
        begin
            c = 7'h30 + ({1'b0, v} - 7'd52);
        end
        else if (v == 6'd62)
        begin
            c = 7'h2B;
        end
        else
        begin
            c = 7'h2F;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### hdl/b64e_front.sv
// Front part of the encoder: accepts message bytes and turns each into a job.
// Depends on b64e_pkg for the job type, phase codes and the alphabet lookup.
`default_nettype none

module b64e_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [7:0]       data_byte,
    input  wire logic             is_final,
    input  wire b64e_pkg::q_stat_t q_stat,
    output logic                  q_push,
    output b64e_pkg::job_t        q_job,
    output logic [1:0]            phase
);
    import b64e_pkg::*;

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [3:0] leftover_reg;
    logic [3:0] leftover_next;
    logic       take;

    // A byte is transferred whenever the job queue has room.
    assign full  = q_stat.full;
    assign take  = push && !q_stat.full;
    assign q_push = take;
    assign phase = phase_reg;

    // Classify the byte by its group position and build its characters.
    always_comb
    begin
        q_job.chars    = {4{PAD_CHAR}};
        q_job.last_idx = 2'd0;
        q_job.is_final = is_final;
        phase_next     = phase_reg;
        leftover_next  = leftover_reg;
        unique case (phase_reg)
            PHASE_1:
            begin
                q_job.chars[0] = sextet_char({leftover_reg[1:0], data_byte[7:4]});
                q_job.chars[1] = sextet_char({data_byte[3:0], 2'b00});
                q_job.last_idx = is_final ? 2'd2 : 2'd0;
                phase_next     = PHASE_2;
                leftover_next  = data_byte[3:0];
            end
            PHASE_2:
            begin
                q_job.chars[0] = sextet_char({leftover_reg, data_byte[7:6]});
                q_job.chars[1] = sextet_char(data_byte[5:0]);
                q_job.last_idx = 2'd1;
                phase_next     = PHASE_0;
                leftover_next  = 4'd0;
            end
            default:
            begin
                // Start of a group; the unused phase code is treated the same way.
                q_job.chars[0] = sextet_char(data_byte[7:2]);
                q_job.chars[1] = sextet_char({data_byte[1:0], 4'b0000});
                q_job.last_idx = is_final ? 2'd3 : 2'd0;
                phase_next     = PHASE_1;
                leftover_next  = {2'b00, data_byte[1:0]};
            end
        endcase
        // The end of a message returns the group state to its start.
        if (is_final)
        begin
            phase_next    = PHASE_0;
            leftover_next = 4'd0;
        end
    end

    // Group state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PHASE_0;
            leftover_reg <= 4'd0;
        end
        else if (take)
        begin
            phase_reg    <= phase_next;
            leftover_reg <= leftover_next;
        end
    end

endmodule

`default_nettype wire

### hdl/b64e_queue.sv
// Short job queue between the front and back parts of the encoder.
// Depends on b64e_pkg for the job and status types.
`default_nettype none

module b64e_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire b64e_pkg::job_t    wr_job,
    input  wire logic              rd_en,
    output b64e_pkg::job_t         rd_job,
    output b64e_pkg::q_stat_t      q_stat
);
    import b64e_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    job_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr;
    logic          do_rd;

    assign q_stat.full     = (count_reg == FULL_CNT);
    assign q_stat.nonempty = (count_reg != '0);
    assign do_wr  = wr_en && !q_stat.full;
    assign do_rd  = rd_en && q_stat.nonempty;
    assign rd_job = slot_reg[rd_ptr_reg];

    // Job storage; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/b64e_back.sv
// Back part of the encoder: serializes queued jobs into one character per transfer.
// Depends on b64e_pkg for the job and status types.
`default_nettype none

module b64e_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire b64e_pkg::q_stat_t q_stat,
    input  wire b64e_pkg::job_t    rd_job,
    output logic                   q_pop,
    output logic [6:0]             code_char,
    output logic                   end_of_text,
    output logic                   empty,
    input  wire logic              pop
);
    import b64e_pkg::*;

    job_t       job_reg;
    logic       job_valid_reg;
    logic [1:0] idx_reg;
    logic       out_valid_reg;
    logic [6:0] out_char_reg;
    logic       out_eot_reg;
    logic       pop_ok;
    logic       advance;
    logic       job_done;

    // A character moves to the output register when it is free or being taken.
    assign pop_ok   = pop && out_valid_reg;
    assign advance  = job_valid_reg && (!out_valid_reg || pop_ok);
    assign job_done = advance && (idx_reg == job_reg.last_idx);
    assign q_pop    = (!job_valid_reg || job_done) && q_stat.nonempty;

    assign code_char   = out_char_reg;
    assign end_of_text = out_eot_reg;
    assign empty       = !out_valid_reg;

    // Current job and character index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else if (q_pop)
        begin
            job_valid_reg <= 1'b1;
            idx_reg       <= 2'd0;
        end
        else if (job_done)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else if (advance)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // Job payload register.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= rd_job;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop_ok)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output character and end mark.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_char_reg <= job_reg.chars[idx_reg];
            out_eot_reg  <= job_reg.is_final && (idx_reg == job_reg.last_idx);
        end
    end

endmodule

`default_nettype wire

### hdl/base64_stream_encoder.sv
// Padded Base64 stream encoder. A transferred byte passes the job queue, the job register
// and the output register before its first character shows. Throughput: one character per
// cycle while pop is held high, set by the output register; a byte yields 1 or 2 characters
// (up to 4 on a final byte), so at most two per non-final byte and four per full three-byte group.
// The job queue decouples input from output.
// Reset (rst_n low, asynchronous) empties the queue and output and restarts the group.
`default_nettype none

module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] data_byte,
    input  wire logic       is_final,
    output logic [6:0]      code_char,
    output logic            end_of_text,
    output logic            empty,
    input  wire logic       pop
);
    import b64e_pkg::*;

    q_stat_t    q_stat;
    job_t       wr_job;
    job_t       rd_job;
    logic       q_push;
    logic       q_pop;
    logic [1:0] phase;

    // Byte intake and classification.
    b64e_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .data_byte (data_byte),
        .is_final  (is_final),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_job     (wr_job),
        .phase     (phase)
    );

    // Queue of pending jobs.
    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_push),
        .wr_job (wr_job),
        .rd_en  (q_pop),
        .rd_job (rd_job),
        .q_stat (q_stat)
    );

    // Character serializer and output register.
    b64e_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .rd_job      (rd_job),
        .q_pop       (q_pop),
        .code_char   (code_char),
        .end_of_text (end_of_text),
        .empty       (empty),
        .pop         (pop)
    );

    // The group position never takes the unused code.
    a_phase_valid: assert property (@(posedge clk) disable iff (!rst_n)
        phase != 2'd3)
        else $error("group phase took the unused code");

    // A final byte returns the group to its start.
    a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full && is_final |=> phase == PHASE_0)
        else $error("group phase not restarted after final byte");

    // An empty queue cannot report full.
    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !q_stat.nonempty |-> !q_stat.full)
        else $error("queue reports full and empty at once");

endmodule

`default_nettype wire

### dv/tb_base64_stream_encoder.sv
`timescale 1ns / 100ps
// Testbench for base64_stream_encoder: drives message bytes into the push/full side and
// checks every popped character against typed table rows or a behavioral encoder kept in this file.
// Depends on hdl/b64e_pkg.sv and hdl/base64_stream_encoder.sv.

module tb_base64_stream_encoder;

    import b64e_pkg::*;

    localparam int RAND_ITEMS   = 400;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 200;
    localparam int HOLD_AFTER   = 150;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_REPORTS  = 40;

    // Standard alphabet, first character in the top byte.
    localparam logic [64*8-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // One character of encoded text as it leaves the block.
    typedef struct packed {
        logic [6:0] ch;
        logic       eot;
    } b64_char_t;

    // One row of the directed table. A row with n_typed of zero is checked against
    // the encoder model; otherwise the typed characters are the expected output.
    typedef struct packed {
        logic [7:0]  data;
        logic        fin;
        logic [2:0]  n_typed;
        logic [31:0] typed;
    } dir_row_t;

    localparam int N_DIR = 20;
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        '{8'h00, 1'b1, 3'd4, "AA=="},        // one zero byte as a whole message
        '{8'hFF, 1'b1, 3'd4, "/w=="},        // one all-ones byte as a whole message
        '{8'h00, 1'b0, 3'd1, 32'("A")},
        '{8'h00, 1'b1, 3'd3, 32'("AA=")},    // two-byte message closes with one pad
        '{8'hFF, 1'b0, 3'd1, 32'("/")},
        '{8'hFF, 1'b0, 3'd1, 32'("/")},
        '{8'hFF, 1'b1, 3'd2, 32'("//")},     // full group closes without pad
        '{8'h4D, 1'b0, 3'd1, 32'("T")},
        '{8'h61, 1'b0, 3'd1, 32'("W")},
        '{8'h6E, 1'b0, 3'd2, 32'("Fu")},
        '{8'hFB, 1'b0, 3'd1, 32'("+")},
        '{8'hF0, 1'b1, 3'd3, 32'("/A=")},
        '{8'h80, 1'b0, 3'd0, 32'h0},
        '{8'h01, 1'b0, 3'd0, 32'h0},
        '{8'h7F, 1'b1, 3'd0, 32'h0},
        '{8'h55, 1'b0, 3'd0, 32'h0},
        '{8'hAA, 1'b1, 3'd0, 32'h0},
        '{8'h3C, 1'b0, 3'd0, 32'h0},
        '{8'hC3, 1'b0, 3'd0, 32'h0},
        '{8'h0F, 1'b1, 3'd0, 32'h0}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] data_byte = 8'h00;
    logic       is_final = 1'b0;
    logic [6:0] code_char;
    logic       end_of_text;
    logic       empty;
    logic       pop = 1'b0;

    // Expected output that travels with the byte being offered.
    logic [2:0]  cur_n_typed = 3'd0;
    logic [31:0] cur_typed = 32'h0;

    // Encoder model state and the characters it has produced so far.
    logic [1:0]  enc_phase;
    logic [3:0]  enc_left;
    b64_char_t   model_out [4];
    int          model_cnt;
    b64_char_t   pending_chars [$];

    int errors = 0;
    int chars_popped = 0;
    int cycles = 0;

    base64_stream_encoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .is_final    (is_final),
        .code_char   (code_char),
        .end_of_text (end_of_text),
        .empty       (empty),
        .pop         (pop)
    );

    always #5 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [6:0] sextet_to_ascii(input logic [5:0] v);
        int pos;
        pos = 63 - int'(v);
        return ALPHABET[pos*8 +: 7];
    endfunction

    task add_model_char(input logic [6:0] ch, input logic eot);
        model_out[model_cnt] = '{ch, eot};
        model_cnt = model_cnt + 1;
    endtask

    // Encodes one byte, updating the group position and the held low bits.
    task encode_byte(input logic [7:0] b, input logic fin);
        model_cnt = 0;
        case (enc_phase)
            PHASE_1:
            begin
                add_model_char(sextet_to_ascii({enc_left[1:0], b[7:4]}), 1'b0);
                enc_left = b[3:0];
                enc_phase = PHASE_2;
                if (fin)
                begin
                    add_model_char(sextet_to_ascii({b[3:0], 2'b00}), 1'b0);
                    add_model_char(PAD_CHAR, 1'b1);
                end
            end
            PHASE_2:
            begin
                add_model_char(sextet_to_ascii({enc_left, b[7:6]}), 1'b0);
                add_model_char(sextet_to_ascii(b[5:0]), fin);
                enc_left = 4'd0;
                enc_phase = PHASE_0;
            end
            default:
            begin
                // The unused phase value also starts a new group.
                add_model_char(sextet_to_ascii(b[7:2]), 1'b0);
                enc_left = {2'b00, b[1:0]};
                enc_phase = PHASE_1;
                if (fin)
                begin
                    add_model_char(sextet_to_ascii({b[1:0], 4'b0000}), 1'b0);
                    add_model_char(PAD_CHAR, 1'b0);
                    add_model_char(PAD_CHAR, 1'b1);
                end
            end
        endcase
        // A final byte closes the message and restarts the group.
        if (fin)
        begin
            enc_phase = PHASE_0;
            enc_left = 4'd0;
        end
    endtask

    // Every edge: record accepted bytes and check popped characters.
    always @(posedge clk)
    begin
        b64_char_t want;
        int k;
        if (rst_n && push && !full)
        begin
            encode_byte(data_byte, is_final);
            if (cur_n_typed != 3'd0)
            begin
                for (k = 0; k < int'(cur_n_typed); k++)
                begin
                    want.ch = cur_typed[(int'(cur_n_typed) - 1 - k)*8 +: 7];
                    want.eot = is_final && (k == int'(cur_n_typed) - 1);
                    pending_chars.push_back(want);
                end
            end
            else
            begin
                for (k = 0; k < model_cnt; k++)
                begin
                    pending_chars.push_back(model_out[k]);
                end
            end
        end
        if (rst_n && pop && !empty)
        begin
            chars_popped <= chars_popped + 1;
            if (pending_chars.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $display("%0t: unexpected character: expected none, got %h eot %b",
                             $time, code_char, end_of_text);
                end
            end
            else
            begin
                want = pending_chars.pop_front();
                if (code_char !== want.ch)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                    begin
                        $display("%0t: code_char mismatch: expected %h got %h",
                                 $time, want.ch, code_char);
                    end
                end
                if (end_of_text !== want.eot)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                    begin
                        $display("%0t: end_of_text mismatch: expected %b got %b",
                                 $time, want.eot, end_of_text);
                    end
                end
            end
        end
    end

    // Wait before an item: random, with calm stretches of back-to-back transfers.
    function automatic int pick_gap(input int idx);
        if ((idx / 50) % 3 == 2)
        begin
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    // Receiver: random pop gaps, plus one long hold so the block backs up.
    initial
    begin
        int gap;
        int idx;
        bit held;
        idx = 0;
        held = 1'b0;
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            gap = pick_gap(idx + 25);
            if (!held && chars_popped >= HOLD_AFTER)
            begin
                held = 1'b1;
                gap = HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
            begin
                @(posedge clk);
            end
            idx++;
        end
    end

    // Sender: reset, directed table, then random messages, then the final verdict.
    initial
    begin
        int i;
        int gap;
        int msg_left;
        logic [7:0] b;
        logic fin;
        logic [2:0] n_typed;
        logic [31:0] typed;

        enc_phase = PHASE_0;
        enc_left = 4'd0;
        msg_left = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < N_DIR + RAND_ITEMS; i++)
        begin
            if (i < N_DIR)
            begin
                b = DIR_ROWS[i].data;
                fin = DIR_ROWS[i].fin;
                n_typed = DIR_ROWS[i].n_typed;
                typed = DIR_ROWS[i].typed;
            end
            else
            begin
                // Mostly short messages, now and then a long one.
                if (msg_left == 0)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        msg_left = $urandom_range(8, 40);
                    end
                    else
                    begin
                        msg_left = $urandom_range(1, 7);
                    end
                end
                b = 8'($urandom_range(0, 255));
                fin = (msg_left == 1) || (i == N_DIR + RAND_ITEMS - 1);
                msg_left--;
                n_typed = 3'd0;
                typed = 32'h0;
            end

            gap = pick_gap(i);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            push <= 1'b1;
            data_byte <= b;
            is_final <= fin;
            cur_n_typed <= n_typed;
            cur_typed <= typed;
            @(posedge clk);
            while (full)
            begin
                @(posedge clk);
            end
        end
        push <= 1'b0;

        // Let the checker record the last transfer before looking at what is left.
        @(posedge clk);

        // Drain, then wait for DRAIN_CYCLES so that anything unexpected can surface.
        while (pending_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && pending_chars.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### files.f
hdl/b64e_pkg.sv
hdl/b64e_front.sv
hdl/b64e_queue.sv
hdl/b64e_back.sv
hdl/base64_stream_encoder.sv
dv/tb_base64_stream_encoder.sv
